[hdl/dpc_pkg.sv]
// debounced pulse counter package: debouncer state encodings, control struct
// and register map constants. no dependencies.
`default_nettype none

package dpc_pkg;

   // width of the hold_ticks register and of the result fields
   localparam int HOLD_WIDTH  = 16;
   localparam int RSP_CNT_W   = 32;

   // register indexes
   localparam logic REG_HOLD_TICKS = 1'b0;

   // reset value of hold_ticks
   localparam logic [HOLD_WIDTH-1:0] HOLD_TICKS_RESET = 16'd40;

   // direction codes
   localparam logic [1:0] DIR_CW  = 2'd0;
   localparam logic [1:0] DIR_CCW = 2'd1;

   // state codes as reported on the result channel
   localparam logic [1:0] DS_UP      = 2'd0;
   localparam logic [1:0] DS_DOWN    = 2'd1;
   localparam logic [1:0] DS_FALLING = 2'd2;
   localparam logic [1:0] DS_RISING  = 2'd3;

   typedef enum logic [3:0] {
      ST_UP      = 4'b0001,
      ST_DOWN    = 4'b0010,
      ST_FALLING = 4'b0100,
      ST_RISING  = 4'b1000
   } fsm_state_type;

   typedef struct packed {
      fsm_state_type state;
      logic          armed;
   } ctrl_type;

   function automatic logic [1:0] state_code(input fsm_state_type st);
      logic [1:0] code;
      unique case (st)
         ST_UP:      code = DS_UP;
         ST_DOWN:    code = DS_DOWN;
         ST_FALLING: code = DS_FALLING;
         ST_RISING:  code = DS_RISING;
         default:    code = DS_UP;
      endcase
      return code;
   endfunction

endpackage

`default_nettype wire

[hdl/dpc_tick_logic.sv]
// debouncer next-state logic for one tick: fsm, hold timer and pulse counts.
// depends on dpc_pkg.
`default_nettype none

module dpc_tick_logic #(
   parameter int COUNT_WIDTH = 32,
   parameter int TIMER_WIDTH = 16
) (
   input  var dpc_pkg::ctrl_type                 ctrl_cur,
   input  wire logic [TIMER_WIDTH-1:0]           timer_cur,
   input  wire logic [COUNT_WIDTH-1:0]           cw_cur,
   input  wire logic [COUNT_WIDTH-1:0]           ccw_cur,
   input  wire logic                             pin_level,
   input  wire logic [1:0]                       direction,
   input  wire logic [dpc_pkg::HOLD_WIDTH-1:0]   hold_ticks,
   output dpc_pkg::ctrl_type                     ctrl_next,
   output logic [TIMER_WIDTH-1:0]                timer_next,
   output logic [COUNT_WIDTH-1:0]                cw_next,
   output logic [COUNT_WIDTH-1:0]                ccw_next,
   output logic                                  rise
);

   localparam int CMP_W = (TIMER_WIDTH > dpc_pkg::HOLD_WIDTH) ? TIMER_WIDTH
                                                              : dpc_pkg::HOLD_WIDTH;

   logic [TIMER_WIDTH-1:0] timer_inc;
   logic                   timer_hit;
   logic                   elapsed;

   // saturating increment
   assign timer_inc = (timer_cur == {TIMER_WIDTH{1'b1}}) ? timer_cur
                                                         : timer_cur + TIMER_WIDTH'(1);
   assign timer_hit = CMP_W'(timer_inc) >= CMP_W'(hold_ticks);

   always_comb begin
      ctrl_next  = ctrl_cur;
      timer_next = timer_cur;
      cw_next    = cw_cur;
      ccw_next   = ccw_cur;
      rise       = 1'b0;
      elapsed    = 1'b0;

      // hold timer runs only while a change is pending
      if (ctrl_cur.state == dpc_pkg::ST_FALLING || ctrl_cur.state == dpc_pkg::ST_RISING) begin
         if (!ctrl_cur.armed) begin
            ctrl_next.armed = 1'b1;
            timer_next      = '0;
         end else begin
            timer_next = timer_inc;
            if (timer_hit) begin
               ctrl_next.armed = 1'b0;
               elapsed         = 1'b1;
            end
         end
      end

      unique case (ctrl_cur.state)
         dpc_pkg::ST_UP: begin
            if (!pin_level) ctrl_next.state = dpc_pkg::ST_FALLING;
         end
         dpc_pkg::ST_DOWN: begin
            if (pin_level) ctrl_next.state = dpc_pkg::ST_RISING;
         end
         dpc_pkg::ST_FALLING: begin
            if (elapsed) ctrl_next.state = pin_level ? dpc_pkg::ST_UP : dpc_pkg::ST_DOWN;
         end
         dpc_pkg::ST_RISING: begin
            if (elapsed) begin
               if (pin_level) begin
                  ctrl_next.state = dpc_pkg::ST_UP;
                  rise            = 1'b1;
                  if (direction == dpc_pkg::DIR_CW) begin
                     cw_next = cw_cur + COUNT_WIDTH'(1);
                  end else if (direction == dpc_pkg::DIR_CCW) begin
                     ccw_next = ccw_cur + COUNT_WIDTH'(1);
                  end
               end else begin
                  ctrl_next.state = dpc_pkg::ST_DOWN;
               end
            end
         end
         default: begin
            ctrl_next.state = dpc_pkg::ST_UP;
         end
      endcase
   end

endmodule

`default_nettype wire

[hdl/debounced_pulse_counter_core.sv]
// debounced pulse counter top level: state registers, result register and csr port.
// depends on dpc_pkg and dpc_tick_logic.
`default_nettype none

// Each request transfer is one timer tick carrying the sampled pulse pin level and
// the motor direction. The debouncer moves between up, falling, down and rising; a
// level change waits until its timer reaches hold_ticks (csr register 0, reset 40)
// before it is confirmed or rejected, and a confirmed rising edge bumps the
// clockwise or counter-clockwise count picked by the direction. Every tick gives
// one response with the new state, a rise flag and both counts. One tick is taken
// per clock unless a response stalls; the state update is combinational between
// the state and response registers, and the response appears the cycle after its
// request transfer. A request is taken while a response is pending if that response
// leaves the same cycle. Write hold_ticks only while no response is pending.

module debounced_pulse_counter_core #(
   parameter int COUNT_WIDTH = 32,
   parameter int TIMER_WIDTH = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_pin_level,
   input  wire logic [1:0]  req_direction,
   // response channel
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_debounce_state,
   output logic             rsp_rise_seen,
   output logic [31:0]      rsp_count_clockwise,
   output logic [31:0]      rsp_count_counterclockwise,
   // csr port
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   dpc_pkg::ctrl_type                ctrl_ff, ctrl_in;
   logic [TIMER_WIDTH-1:0]           timer_ff, timer_in;
   logic [COUNT_WIDTH-1:0]           cw_ff, cw_in;
   logic [COUNT_WIDTH-1:0]           ccw_ff, ccw_in;
   logic [dpc_pkg::HOLD_WIDTH-1:0]   hold_ticks_ff;
   logic                             rise;
   logic                             req_xfer;
   logic                             csr_write;
   logic                             csr_hit;

   logic                             rsp_valid_ff;
   logic [1:0]                       rsp_state_ff;
   logic                             rsp_rise_ff;
   logic [dpc_pkg::RSP_CNT_W-1:0]    rsp_cw_ff;
   logic [dpc_pkg::RSP_CNT_W-1:0]    rsp_ccw_ff;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_xfer  = req_valid && req_ready;

   // csr decode: byte address 4*i, bit 2 selects the register index
   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[2] == dpc_pkg::REG_HOLD_TICKS);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_hit;
   assign csr_prdata = csr_hit ? 32'(hold_ticks_ff) : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ticks_ff <= dpc_pkg::HOLD_TICKS_RESET;
      end else if (csr_write) begin
         hold_ticks_ff <= csr_pwdata[dpc_pkg::HOLD_WIDTH-1:0];
      end
   end

   dpc_tick_logic #(
      .COUNT_WIDTH (COUNT_WIDTH),
      .TIMER_WIDTH (TIMER_WIDTH)
   ) u_tick (
      .ctrl_cur   (ctrl_ff),
      .timer_cur  (timer_ff),
      .cw_cur     (cw_ff),
      .ccw_cur    (ccw_ff),
      .pin_level  (req_pin_level),
      .direction  (req_direction),
      .hold_ticks (hold_ticks_ff),
      .ctrl_next  (ctrl_in),
      .timer_next (timer_in),
      .cw_next    (cw_in),
      .ccw_next   (ccw_in),
      .rise       (rise)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff.state <= dpc_pkg::ST_UP;
         ctrl_ff.armed <= 1'b0;
         timer_ff      <= '0;
         cw_ff         <= '0;
         ccw_ff        <= '0;
      end else if (req_xfer) begin
         ctrl_ff  <= ctrl_in;
         timer_ff <= timer_in;
         cw_ff    <= cw_in;
         ccw_ff   <= ccw_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_xfer) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // payload loads only on a request transfer, so a stalled response holds
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         rsp_state_ff <= dpc_pkg::state_code(ctrl_in.state);
         rsp_rise_ff  <= rise;
         rsp_cw_ff    <= dpc_pkg::RSP_CNT_W'(cw_in);
         rsp_ccw_ff   <= dpc_pkg::RSP_CNT_W'(ccw_in);
      end
   end

   assign rsp_valid                  = rsp_valid_ff;
   assign rsp_debounce_state         = rsp_state_ff;
   assign rsp_rise_seen              = rsp_rise_ff;
   assign rsp_count_clockwise        = rsp_cw_ff;
   assign rsp_count_counterclockwise = rsp_ccw_ff;

endmodule

`default_nettype wire

[hdl/dpc_checker.sv]
// port-level checker for debounced_pulse_counter_core and its bind statement.
// depends on dpc_pkg.
`default_nettype none

module dpc_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [1:0]  rsp_debounce_state,
   input wire logic        rsp_rise_seen,
   input wire logic [31:0] rsp_count_clockwise,
   input wire logic [31:0] rsp_count_counterclockwise
);

   // stalled response keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_debounce_state)
         && $stable(rsp_rise_seen) && $stable(rsp_count_clockwise)
         && $stable(rsp_count_counterclockwise))
      else $error("response changed while stalled");

   // a confirmed rise always lands in the up state
   a_rise_up: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_rise_seen |-> rsp_debounce_state == dpc_pkg::DS_UP)
      else $error("rise flagged outside up state");

   // one response per request transfer, no more
   a_req_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("request transfer gave no response");

   a_rsp_drains: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !(req_valid && req_ready) |=> !rsp_valid)
      else $error("response repeated");

   // no pending response means the request side is open
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request blocked with empty response stage");

endmodule

bind debounced_pulse_counter_core dpc_checker u_dpc_checker (
   .clock                      (clock),
   .reset                      (reset),
   .req_valid                  (req_valid),
   .req_ready                  (req_ready),
   .rsp_valid                  (rsp_valid),
   .rsp_ready                  (rsp_ready),
   .rsp_debounce_state         (rsp_debounce_state),
   .rsp_rise_seen              (rsp_rise_seen),
   .rsp_count_clockwise        (rsp_count_clockwise),
   .rsp_count_counterclockwise (rsp_count_counterclockwise)
);

`default_nettype wire

[tb/debounced_pulse_counter_core_tb.sv]
// testbench for debounced_pulse_counter_core: drives timer ticks, predicts every response
// with its own debouncer model and checks it field by field.
// depends on dpc_pkg and the debounced_pulse_counter_core rtl.
`default_nettype none

module debounced_pulse_counter_core_tb;

   typedef struct {
      logic       pin;
      logic [1:0] dir;
   } tick_in_type;

   typedef struct {
      logic [1:0]  code;
      logic        rise;
      logic [31:0] cw;
      logic [31:0] ccw;
   } tick_out_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_pin_level = 1'b1;
   logic [1:0]  req_direction = dpc_pkg::DIR_CW;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_debounce_state;
   logic        rsp_rise_seen;
   logic [31:0] rsp_count_clockwise;
   logic [31:0] rsp_count_counterclockwise;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   tick_in_type  pending_ticks[$];
   tick_out_type expected_outputs[$];
   bit           gaps_on = 1'b1;
   bit           failed = 1'b0;
   int           send_gap = 0;
   int           recv_stall = 0;

   // debouncer prediction state
   logic [1:0]                     dbc_state;
   logic [15:0]                    hold_count;
   logic                           hold_armed;
   logic [dpc_pkg::HOLD_WIDTH-1:0] hold_limit;
   logic [31:0]                    cw_pulses;
   logic [31:0]                    ccw_pulses;

   debounced_pulse_counter_core dut (
      .clock                      (clock),
      .reset                      (reset),
      .req_valid                  (req_valid),
      .req_ready                  (req_ready),
      .req_pin_level              (req_pin_level),
      .req_direction              (req_direction),
      .rsp_valid                  (rsp_valid),
      .rsp_ready                  (rsp_ready),
      .rsp_debounce_state         (rsp_debounce_state),
      .rsp_rise_seen              (rsp_rise_seen),
      .rsp_count_clockwise        (rsp_count_clockwise),
      .rsp_count_counterclockwise (rsp_count_counterclockwise),
      .csr_psel                   (csr_psel),
      .csr_penable                (csr_penable),
      .csr_pwrite                 (csr_pwrite),
      .csr_paddr                  (csr_paddr),
      .csr_pwdata                 (csr_pwdata),
      .csr_prdata                 (csr_prdata),
      .csr_pready                 (csr_pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("Regression FAIL");
      $finish;
   end

   function automatic tick_out_type debounce_tick(input logic pin, input logic [1:0] dir);
      tick_out_type r;
      logic         elapsed;
      elapsed = 1'b0;
      r.rise = 1'b0;
      // hold timer only runs while a level change is pending
      if (dbc_state == dpc_pkg::DS_FALLING || dbc_state == dpc_pkg::DS_RISING) begin
         if (!hold_armed) begin
            hold_armed = 1'b1;
            hold_count = '0;
         end else begin
            if (hold_count != '1)
               hold_count = hold_count + 1'b1;
            if (hold_count >= hold_limit) begin
               hold_armed = 1'b0;
               elapsed = 1'b1;
            end
         end
      end
      case (dbc_state)
         dpc_pkg::DS_UP: begin
            if (!pin)
               dbc_state = dpc_pkg::DS_FALLING;
         end
         dpc_pkg::DS_DOWN: begin
            if (pin)
               dbc_state = dpc_pkg::DS_RISING;
         end
         dpc_pkg::DS_FALLING: begin
            if (elapsed)
               dbc_state = pin ? dpc_pkg::DS_UP : dpc_pkg::DS_DOWN;
         end
         dpc_pkg::DS_RISING: begin
            if (elapsed && pin) begin
               dbc_state = dpc_pkg::DS_UP;
               r.rise = 1'b1;
               if (dir == dpc_pkg::DIR_CW)
                  cw_pulses = cw_pulses + 1'b1;
               else if (dir == dpc_pkg::DIR_CCW)
                  ccw_pulses = ccw_pulses + 1'b1;
            end else if (elapsed) begin
               dbc_state = dpc_pkg::DS_DOWN;
            end
         end
         default: dbc_state = dpc_pkg::DS_UP;
      endcase
      r.code = dbc_state;
      r.cw = cw_pulses;
      r.ccw = ccw_pulses;
      return r;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
         failed = 1'b1;
      end
   endtask

   // request driver
   always @(posedge clock) begin : request_driver
      tick_in_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (gaps_on && pending_ticks.size() > 0 && $urandom_range(0, 5) == 0) begin
            send_gap = $urandom_range(0, 14);
            req_valid <= 1'b0;
         end else if (pending_ticks.size() > 0) begin
            nxt = pending_ticks.pop_front();
            req_valid <= 1'b1;
            req_pin_level <= nxt.pin;
            req_direction <= nxt.dir;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (recv_stall > 0) begin
         recv_stall--;
         rsp_ready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
         recv_stall = $urandom_range(0, 14);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // monitor: check the response transfer first, then predict the new request
   always @(posedge clock) begin : tick_monitor
      tick_out_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_outputs.size() == 0) begin
               $display("%0t: unexpected response, expected none actual state %0h",
                        $time, rsp_debounce_state);
               failed = 1'b1;
            end else begin
               want = expected_outputs.pop_front();
               check_field("debounce_state", 32'(want.code), 32'(rsp_debounce_state));
               check_field("rise_seen", 32'(want.rise), 32'(rsp_rise_seen));
               check_field("count_clockwise", want.cw, rsp_count_clockwise);
               check_field("count_counterclockwise", want.ccw, rsp_count_counterclockwise);
            end
         end
         if (req_valid && req_ready)
            expected_outputs.push_back(debounce_tick(req_pin_level, req_direction));
      end
   end

   task automatic queue_tick(input logic pin, input logic [1:0] dir);
      tick_in_type t;
      t.pin = pin;
      t.dir = dir;
      pending_ticks.push_back(t);
   endtask

   task automatic queue_run(input logic pin, input logic [1:0] dir, input int len);
      repeat (len) queue_tick(pin, dir);
   endtask

   // level runs around the hold time, some of them short enough to be bounces
   task automatic queue_pulse_train(input int budget);
      int         pushed;
      int         len;
      logic       level;
      logic [1:0] dir;
      pushed = 0;
      level = 1'($urandom_range(0, 1));
      while (pushed < budget) begin
         if ($urandom_range(0, 3) == 0)
            len = $urandom_range(1, int'(hold_limit) + 1);
         else
            len = int'(hold_limit) + $urandom_range(2, 6);
         dir = 2'($urandom_range(0, 3));
         repeat (len) begin
            queue_tick(level, ($urandom_range(0, 3) == 0) ? 2'($urandom_range(0, 3)) : dir);
            pushed++;
         end
         level = ~level;
      end
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_ticks.size() != 0 || req_valid || expected_outputs.size() != 0);
   endtask

   task automatic write_hold_ticks(input logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= 3'(4 * dpc_pkg::REG_HOLD_TICKS);
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      // register takes the value at this edge
      @(posedge clock);
      hold_limit = value[dpc_pkg::HOLD_WIDTH-1:0];
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(negedge clock);
   endtask

   task automatic random_phase(input logic [31:0] hold, input bit gaps, input int budget);
      write_hold_ticks(hold);
      gaps_on = gaps;
      queue_pulse_train(budget);
      wait_drained();
   endtask

   initial begin
      dbc_state = dpc_pkg::DS_UP;
      hold_count = '0;
      hold_armed = 1'b0;
      hold_limit = dpc_pkg::HOLD_TICKS_RESET;
      cw_pulses = '0;
      ccw_pulses = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset hold time: one full fall and one counter-clockwise rise
      queue_run(1'b0, dpc_pkg::DIR_CW, 42);
      queue_run(1'b1, dpc_pkg::DIR_CCW, 42);
      wait_drained();

      // hold of one: bounce on each edge, then a count in each direction
      write_hold_ticks(32'd1);
      queue_tick(1'b1, dpc_pkg::DIR_CW);
      queue_run(1'b0, dpc_pkg::DIR_CW, 1);
      queue_run(1'b1, dpc_pkg::DIR_CW, 2);
      queue_run(1'b0, dpc_pkg::DIR_CW, 3);
      queue_run(1'b1, dpc_pkg::DIR_CW, 2);
      queue_tick(1'b0, dpc_pkg::DIR_CW);
      queue_run(1'b1, dpc_pkg::DIR_CW, 3);
      queue_run(1'b0, dpc_pkg::DIR_CCW, 3);
      queue_run(1'b1, dpc_pkg::DIR_CCW, 3);
      wait_drained();

      // hold of zero, upper data bits set: other directions count nothing
      write_hold_ticks(32'h5a5a_0000);
      queue_run(1'b0, 2'd2, 3);
      queue_run(1'b1, 2'd2, 3);
      queue_run(1'b0, 2'd3, 3);
      queue_run(1'b1, 2'd3, 3);
      wait_drained();

      random_phase(32'd2, 1'b1, 50);
      random_phase(32'd7, 1'b1, 50);
      random_phase(32'($urandom_range(3, 12)), 1'b0, 40);
      random_phase(32'd5, 1'b1, 60);
      write_hold_ticks(32'd1);
      gaps_on = 1'b1;
      queue_pulse_train(40);
      // settle in the up state before the longest hold
      queue_run(1'b1, dpc_pkg::DIR_CW, 4);
      wait_drained();

      // longest hold, no gaps from here on
      write_hold_ticks(32'hffff_ffff);
      gaps_on = 1'b0;
      repeat (30) queue_tick(1'b0, 2'($urandom_range(0, 3)));
      wait_drained();

      repeat (10) @(posedge clock);
      if (failed || expected_outputs.size() != 0) begin
         $display("Regression FAIL");
      end else begin
         $display("Regression PASS");
      end
      $finish;
   end

endmodule

`default_nettype wire

[files.f]
hdl/dpc_pkg.sv
hdl/dpc_tick_logic.sv
hdl/debounced_pulse_counter_core.sv
hdl/dpc_checker.sv
tb/debounced_pulse_counter_core_tb.sv
